>>> rtl/core/ddo_pkg.sv
package ddo_pkg;

  // Field widths of one request and one result.
  localparam int POS_W   = 32;
  localparam int ANG_W   = 19;
  localparam int TICK_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic        [1:0]        op_t;
  typedef logic signed [TICK_W-1:0] tick_t;
  typedef logic        [15:0]       ms_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic        [CFG_W-1:0]  cfg_t;

  // Operation codes.
  localparam op_t OP_ENC    = 2'd0;
  localparam op_t OP_FIX    = 2'd1;
  localparam op_t OP_DISARM = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_REV = 2'd2;

  localparam cfg_t WHEEL_RADIUS_RST  = 16'd3255;
  localparam cfg_t WHEEL_BASE_RST    = 16'd13205;
  localparam cfg_t TICKS_PER_REV_RST = 16'd360;

  // Angle codes carry 16 fraction bits; pi rounds to 205887.
  localparam logic signed [20:0] PI_CODE     = 21'sd205887;
  localparam logic signed [20:0] NEG_PI_CODE = -21'sd205887;
  localparam logic signed [20:0] TWO_PI_CODE = 21'sd411774;
  localparam logic        [18:0] TWO_PI_MAG  = 19'd411774;

  // Q30 constants of the rotation unit.
  localparam logic signed [33:0] PI_Q30          = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [33:0] NEG_HALF_PI_Q30 = -34'sd1686629713;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic        [4:0]  CORDIC_LAST     = 5'd29;

  // Two pi with 24 fraction bits, used for straight-line distance.
  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  // Adds or subtracts one full turn when the angle lies outside [-pi, pi].
  function automatic logic signed [20:0] wrap_once(input logic signed [20:0] v);
    logic signed [20:0] r;
    if (v > PI_CODE) begin
      r = v - TWO_PI_CODE;
    end else if (v < NEG_PI_CODE) begin
      r = v + TWO_PI_CODE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic pos_t sat_pos(input logic signed [39:0] v);
    pos_t r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ddo_if.sv
interface ddo_req_if import ddo_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  tick_t delta_left;
  tick_t delta_right;
  ms_t   interval_ms;
  pos_t  fix_x;
  pos_t  fix_y;
  ang_t  fix_theta;

  modport source (output valid, operation, delta_left, delta_right, interval_ms,
                  fix_x, fix_y, fix_theta, input ready);
  modport sink (input valid, operation, delta_left, delta_right, interval_ms,
                fix_x, fix_y, fix_theta, output ready);
endinterface

interface ddo_rsp_if import ddo_pkg::*; ();
  logic valid;
  logic ready;
  pos_t pose_x;
  pos_t pose_y;
  ang_t pose_theta;

  modport source (output valid, pose_x, pose_y, pose_theta, input ready);
  modport sink (input valid, pose_x, pose_y, pose_theta, output ready);
endinterface

>>> rtl/core/diff_drive_odometry_update_core.sv
// Channel  | Direction | Handshake     | Carries
// req      | in        | valid / ready | operation, tick deltas, interval, pose fix
// rsp      | out       | valid / ready | pose_x, pose_y, pose_theta
// cfg      | in        | cfg_we only   | cfg_index, cfg_data (no read-back)
//
// A pose fix, a disarm, an unused code or an encoder request that is ignored
// completes in the cycle it is accepted. An encoder request that moves the
// pose runs the 60-step radix-2 divider once on a straight move and three times
// on a turn, as well as the 30-step rotation unit and the shift-add multiplier.
// Reset is synchronous, clears the pose and the armed flag and reloads the
// register defaults.
// A new request is taken while a finished pose still waits on rsp; only the
// next result waits for rsp to drain.
module diff_drive_odometry_update_core import ddo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_t                 cfg_data,
  ddo_req_if.sink              req,
  ddo_rsp_if.source            rsp
);

  // Shared arithmetic widths. The multiplier accumulates one multiplier bit
  // per cycle; the divider retires one quotient bit per cycle.
  localparam int MUL_W = 68;
  localparam int MB_W  = 33;
  localparam int DIV_N = 60;
  localparam int DVS_W = 41;
  localparam int AMT_W = 36;
  localparam int DX_W  = 39;
  localparam logic [5:0] DIV_LAST = 6'(DIV_N - 1);
  localparam logic signed [MUL_W:0] MUL_HALF = (MUL_W + 1)'(64'sd536870912);

  // Sequencer states.
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_C0_GO  = 5'd1;
  localparam logic [4:0] ST_C0_W   = 5'd2;
  localparam logic [4:0] ST_SM1_GO = 5'd3;
  localparam logic [4:0] ST_SM1_W  = 5'd4;
  localparam logic [4:0] ST_SM2_GO = 5'd5;
  localparam logic [4:0] ST_SM2_W  = 5'd6;
  localparam logic [4:0] ST_SDV_GO = 5'd7;
  localparam logic [4:0] ST_SDV_W  = 5'd8;
  localparam logic [4:0] ST_TM1_GO = 5'd9;
  localparam logic [4:0] ST_TM1_W  = 5'd10;
  localparam logic [4:0] ST_TM2_GO = 5'd11;
  localparam logic [4:0] ST_TM2_W  = 5'd12;
  localparam logic [4:0] ST_TM3_GO = 5'd13;
  localparam logic [4:0] ST_TM3_W  = 5'd14;
  localparam logic [4:0] ST_TDV_GO = 5'd15;
  localparam logic [4:0] ST_TDV_W  = 5'd16;
  localparam logic [4:0] ST_TMD_GO = 5'd17;
  localparam logic [4:0] ST_TMD_W  = 5'd18;
  localparam logic [4:0] ST_C1_GO  = 5'd19;
  localparam logic [4:0] ST_C1_W   = 5'd20;
  localparam logic [4:0] ST_RM_GO  = 5'd21;
  localparam logic [4:0] ST_RM_W   = 5'd22;
  localparam logic [4:0] ST_RDV_GO = 5'd23;
  localparam logic [4:0] ST_RDV_W  = 5'd24;
  localparam logic [4:0] ST_MX_GO  = 5'd25;
  localparam logic [4:0] ST_MX_W   = 5'd26;
  localparam logic [4:0] ST_MY_GO  = 5'd27;
  localparam logic [4:0] ST_MY_W   = 5'd28;
  localparam logic [4:0] ST_DONE   = 5'd29;

  logic [4:0] st;

  // Configuration registers.
  cfg_t wheel_radius, wheel_base, ticks_per_rev;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius  <= WHEEL_RADIUS_RST;
      wheel_base    <= WHEEL_BASE_RST;
      ticks_per_rev <= TICKS_PER_REV_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_WHEEL_RADIUS) begin
        wheel_radius <= cfg_data;
      end
      if (cfg_index == REG_WHEEL_BASE) begin
        wheel_base <= cfg_data;
      end
      if (cfg_index == REG_TICKS_PER_REV) begin
        ticks_per_rev <= cfg_data;
      end
    end
  end

  // A zero wheel base or tick count is treated as one.
  cfg_t ll_eff, tt_eff;
  assign ll_eff = (wheel_base == '0) ? 16'd1 : wheel_base;
  assign tt_eff = (ticks_per_rev == '0) ? 16'd1 : ticks_per_rev;

  // Tracker state.
  logic armed;
  pos_t px, py;
  ang_t h;

  // Per-request working registers.
  logic signed [16:0] dl;
  logic signed [17:0] dd, ss;
  ang_t               nh;
  logic signed [31:0] s0, c0, s1, c1;
  logic [DIV_N-1:0]   t1;
  logic [31:0]        den;
  logic               qneg;
  logic [AMT_W-1:0]   amt_mag;
  logic               amt_neg;
  logic signed [32:0] tx, ty;
  logic signed [DX_W-1:0] dx, dy;

  // Output register. It loads when the finished pose finds it empty or
  // draining in the same cycle.
  logic ovalid;
  pos_t opx, opy;
  ang_t oth;
  logic out_load;
  assign out_load = (st == ST_DONE) && (!ovalid || rsp.ready);

  // Shift-add multiplier.
  logic [MUL_W-1:0] ma, mp;
  logic [MB_W-1:0]  mb;
  logic             mul_busy, pneg;

  // Radix-2 restoring divider; the dividend register fills with quotient bits.
  logic [DIV_N-1:0] dn;
  logic [DVS_W-1:0] drem, dvs;
  logic [5:0]       dcnt;
  logic             div_busy;

  // Rotation unit.
  logic signed [31:0] cx, cy;
  logic signed [33:0] cz;
  logic [4:0]         ci;
  logic               cflip, cor_busy;

  // Incoming deltas are negated before use.
  logic signed [16:0] dl_in, dr_in;
  logic signed [17:0] dd_in, ss_in;
  assign dl_in = -$signed({req.delta_left[15], req.delta_left});
  assign dr_in = -$signed({req.delta_right[15], req.delta_right});
  assign dd_in = {dr_in[16], dr_in} - {dl_in[16], dl_in};
  assign ss_in = {dl_in[16], dl_in} + {dr_in[16], dr_in};

  logic [16:0] dl_mag;
  logic [17:0] dd_mag, ss_mag;
  logic [32:0] tx_mag, ty_mag;
  assign dl_mag = dl[16] ? $unsigned(-dl) : $unsigned(dl);
  assign dd_mag = dd[17] ? $unsigned(-dd) : $unsigned(dd);
  assign ss_mag = ss[17] ? $unsigned(-ss) : $unsigned(ss);
  assign tx_mag = tx[32] ? $unsigned(-tx) : $unsigned(tx);
  assign ty_mag = ty[32] ? $unsigned(-ty) : $unsigned(ty);

  // Rotation unit start: reduce the angle into [-pi, pi], scale to Q30 and
  // fold into [-pi/2, pi/2], remembering to negate the results afterwards.
  ang_t               cor_ang;
  logic signed [20:0] cor_r;
  logic signed [33:0] cor_z0, cor_zl;
  logic               cor_fl;
  assign cor_ang = (st == ST_C0_GO) ? h : nh;
  assign cor_r   = wrap_once({{2{cor_ang[ANG_W-1]}}, cor_ang});
  assign cor_z0  = {cor_r[18], cor_r[18:0], 14'b0};

  always_comb begin
    if (cor_z0 > HALF_PI_Q30) begin
      cor_zl = cor_z0 - PI_Q30;
      cor_fl = 1'b1;
    end else if (cor_z0 < NEG_HALF_PI_Q30) begin
      cor_zl = cor_z0 + PI_Q30;
      cor_fl = 1'b1;
    end else begin
      cor_zl = cor_z0;
      cor_fl = 1'b0;
    end
  end

  logic signed [31:0] cor_xs, cor_ys, cor_s, cor_c;
  logic signed [33:0] cor_at;
  assign cor_xs = cx >>> ci;
  assign cor_ys = cy >>> ci;
  assign cor_at = $signed({4'b0, atan_q30(ci)});
  assign cor_s  = cflip ? -cy : cy;
  assign cor_c  = cflip ? -cx : cx;

  // Signed product rounded back from Q30 to 16 fraction bits, half up.
  logic signed [MUL_W:0] mul_sgn, mul_fix, mul_rnd;
  logic signed [DX_W-1:0] mul_res;
  assign mul_sgn = $signed({1'b0, mp});
  assign mul_fix = pneg ? -mul_sgn : mul_sgn;
  assign mul_rnd = mul_fix + MUL_HALF;
  assign mul_res = mul_rnd[MUL_W:30];

  // One divider step.
  logic [DVS_W+1:0] div_trial;
  assign div_trial = {1'b0, drem, dn[DIV_N-1]} - {2'b0, dvs};

  // Heading change: the remainder modulo a full turn takes the sign of the
  // quotient, then the sum with the old heading is wrapped once.
  logic signed [20:0] a_val, h_sum, nh_turn, h_wrap;
  assign a_val   = qneg ? -$signed({2'b0, drem[18:0]}) : $signed({2'b0, drem[18:0]});
  assign h_sum   = {{2{h[ANG_W-1]}}, h} + a_val;
  assign nh_turn = wrap_once(h_sum);
  assign h_wrap  = wrap_once({{2{h[ANG_W-1]}}, h});

  logic signed [39:0] px_sum, py_sum;
  assign px_sum = {{8{px[POS_W-1]}}, px} + {dx[DX_W-1], dx};
  assign py_sum = {{8{py[POS_W-1]}}, py} + {dy[DX_W-1], dy};

  assign req.ready      = (st == ST_IDLE);
  assign rsp.valid      = ovalid;
  assign rsp.pose_x     = opx;
  assign rsp.pose_y     = opy;
  assign rsp.pose_theta = oth;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      armed    <= 1'b0;
      px       <= '0;
      py       <= '0;
      h        <= '0;
      ovalid   <= 1'b0;
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      cor_busy <= 1'b0;
    end else begin
      // Multiplier: one bit of mb per cycle.
      if (mul_busy) begin
        if (mb[0]) begin
          mp <= mp + ma;
        end
        ma <= {ma[MUL_W-2:0], 1'b0};
        mb <= {1'b0, mb[MB_W-1:1]};
        if (mb[MB_W-1:1] == '0) begin
          mul_busy <= 1'b0;
        end
      end

      // Divider: one quotient bit per cycle.
      if (div_busy) begin
        if (!div_trial[DVS_W+1]) begin
          drem <= div_trial[DVS_W-1:0];
          dn   <= {dn[DIV_N-2:0], 1'b1};
        end else begin
          drem <= {drem[DVS_W-2:0], dn[DIV_N-1]};
          dn   <= {dn[DIV_N-2:0], 1'b0};
        end
        dcnt <= dcnt - 6'd1;
        if (dcnt == '0) begin
          div_busy <= 1'b0;
        end
      end

      // Rotation unit: one micro-rotation per cycle.
      if (cor_busy) begin
        if (!cz[33]) begin
          cx <= cx - cor_ys;
          cy <= cy + cor_xs;
          cz <= cz - cor_at;
        end else begin
          cx <= cx + cor_ys;
          cy <= cy - cor_xs;
          cz <= cz + cor_at;
        end
        ci <= ci + 5'd1;
        if (ci == CORDIC_LAST) begin
          cor_busy <= 1'b0;
        end
      end

      if (out_load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end

      unique case (st)
        ST_IDLE: begin
          if (req.valid) begin
            if (req.operation == OP_FIX) begin
              px    <= req.fix_x;
              py    <= req.fix_y;
              h     <= req.fix_theta;
              armed <= 1'b1;
            end else if (req.operation == OP_DISARM) begin
              armed <= 1'b0;
            end else if (req.operation == OP_ENC && armed && req.interval_ms != '0) begin
              dl <= dl_in;
              dd <= dd_in;
              ss <= ss_in;
              st <= ST_C0_GO;
            end
          end
        end
        ST_C0_GO, ST_C1_GO: begin
          cx       <= CORDIC_GAIN_Q30;
          cy       <= '0;
          cz       <= cor_zl;
          cflip    <= cor_fl;
          ci       <= '0;
          cor_busy <= 1'b1;
          st       <= (st == ST_C0_GO) ? ST_C0_W : ST_C1_W;
        end
        ST_C0_W: begin
          if (!cor_busy) begin
            s0 <= cor_s;
            c0 <= cor_c;
            st <= (dd == '0) ? ST_SM1_GO : ST_TM1_GO;
          end
        end
        // Straight move: distance = 2pi * r * dl / T, rounded.
        ST_SM1_GO: begin
          ma       <= MUL_W'(TWO_PI_Q24);
          mb       <= MB_W'(wheel_radius);
          mp       <= '0;
          mul_busy <= 1'b1;
          st       <= ST_SM1_W;
        end
        ST_SM1_W: begin
          if (!mul_busy) begin
            st <= ST_SM2_GO;
          end
        end
        ST_SM2_GO: begin
          ma       <= mp;
          mb       <= MB_W'(dl_mag);
          mp       <= '0;
          mul_busy <= 1'b1;
          st       <= ST_SM2_W;
        end
        ST_SM2_W: begin
          if (!mul_busy) begin
            st <= ST_SDV_GO;
          end
        end
        ST_SDV_GO: begin
          dn       <= mp[DIV_N-1:0] + DIV_N'({tt_eff, 23'b0});
          dvs      <= DVS_W'({tt_eff, 24'b0});
          drem     <= '0;
          dcnt     <= DIV_LAST;
          div_busy <= 1'b1;
          qneg     <= dl[16];
          st       <= ST_SDV_W;
        end
        ST_SDV_W: begin
          if (!div_busy) begin
            amt_mag <= dn[AMT_W-1:0];
            amt_neg <= qneg;
            tx      <= {c0[31], c0};
            ty      <= {s0[31], s0};
            nh      <= h_wrap[ANG_W-1:0];
            st      <= ST_MX_GO;
          end
        end
        // Turn: heading change = 2pi * r * D / (T * l), rounded.
        ST_TM1_GO: begin
          ma       <= MUL_W'(TWO_PI_MAG);
          mb       <= MB_W'(wheel_radius);
          mp       <= '0;
          mul_busy <= 1'b1;
          st       <= ST_TM1_W;
        end
        ST_TM1_W: begin
          if (!mul_busy) begin
            st <= ST_TM2_GO;
          end
        end
        ST_TM2_GO: begin
          ma       <= mp;
          mb       <= MB_W'(dd_mag);
          mp       <= '0;
          mul_busy <= 1'b1;
          st       <= ST_TM2_W;
        end
        ST_TM2_W: begin
          if (!mul_busy) begin
            st <= ST_TM3_GO;
          end
        end
        ST_TM3_GO: begin
          t1       <= mp[DIV_N-1:0];
          ma       <= MUL_W'(tt_eff);
          mb       <= MB_W'(ll_eff);
          mp       <= '0;
          mul_busy <= 1'b1;
          st       <= ST_TM3_W;
        end
        ST_TM3_W: begin
          if (!mul_busy) begin
            den <= mp[31:0];
            st  <= ST_TDV_GO;
          end
        end
        ST_TDV_GO: begin
          dn       <= t1 + DIV_N'(den[31:1]);
          dvs      <= DVS_W'(den);
          drem     <= '0;
          dcnt     <= DIV_LAST;
          div_busy <= 1'b1;
          qneg     <= dd[17];
          st       <= ST_TDV_W;
        end
        ST_TDV_W: begin
          if (!div_busy) begin
            st <= ST_TMD_GO;
          end
        end
        // The quotient is still in dn; divide it by a full turn.
        ST_TMD_GO: begin
          dvs      <= DVS_W'(TWO_PI_MAG);
          drem     <= '0;
          dcnt     <= DIV_LAST;
          div_busy <= 1'b1;
          st       <= ST_TMD_W;
        end
        ST_TMD_W: begin
          if (!div_busy) begin
            nh <= nh_turn[ANG_W-1:0];
            st <= ST_C1_GO;
          end
        end
        ST_C1_W: begin
          if (!cor_busy) begin
            s1 <= cor_s;
            c1 <= cor_c;
            st <= ST_RM_GO;
          end
        end
        // Turn radius = l * S / (2 D), rounded.
        ST_RM_GO: begin
          ma       <= MUL_W'(ll_eff);
          mb       <= MB_W'(ss_mag);
          mp       <= '0;
          mul_busy <= 1'b1;
          st       <= ST_RM_W;
        end
        ST_RM_W: begin
          if (!mul_busy) begin
            st <= ST_RDV_GO;
          end
        end
        ST_RDV_GO: begin
          dn       <= mp[DIV_N-1:0] + DIV_N'(dd_mag);
          dvs      <= DVS_W'({dd_mag, 1'b0});
          drem     <= '0;
          dcnt     <= DIV_LAST;
          div_busy <= 1'b1;
          qneg     <= ss[17] ^ dd[17];
          st       <= ST_RDV_W;
        end
        ST_RDV_W: begin
          if (!div_busy) begin
            amt_mag <= dn[AMT_W-1:0];
            amt_neg <= qneg;
            tx      <= {s1[31], s1} - {s0[31], s0};
            ty      <= {c0[31], c0} - {c1[31], c1};
            st      <= ST_MX_GO;
          end
        end
        // Position steps: amount times the trig term, back to Q16.
        ST_MX_GO: begin
          ma       <= MUL_W'(amt_mag);
          mb       <= tx_mag;
          mp       <= '0;
          pneg     <= amt_neg ^ tx[32];
          mul_busy <= 1'b1;
          st       <= ST_MX_W;
        end
        ST_MX_W: begin
          if (!mul_busy) begin
            dx <= mul_res;
            st <= ST_MY_GO;
          end
        end
        ST_MY_GO: begin
          ma       <= MUL_W'(amt_mag);
          mb       <= ty_mag;
          mp       <= '0;
          pneg     <= amt_neg ^ ty[32];
          mul_busy <= 1'b1;
          st       <= ST_MY_W;
        end
        ST_MY_W: begin
          if (!mul_busy) begin
            dy <= mul_res;
            st <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            px     <= sat_pos(px_sum);
            py     <= sat_pos(py_sum);
            h      <= nh;
            opx    <= sat_pos(px_sum);
            opy    <= sat_pos(py_sum);
            oth    <= nh;
            st     <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/ddo_check.sv
module ddo_check import ddo_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input op_t  req_operation,
  input logic rsp_valid,
  input logic rsp_ready,
  input pos_t rsp_pose_x,
  input pos_t rsp_pose_y,
  input ang_t rsp_pose_theta
);

  // A result waiting on a stalled sink holds still.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pose_x) &&
      $stable(rsp_pose_y) && $stable(rsp_pose_theta))
    else $error("result changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Requests other than encoder updates finish in the cycle they are taken.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_operation != OP_ENC |=> req_ready)
    else $error("non-encoder request held the block busy");

  // A new result comes only out of a running update.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared while the block was idle");

endmodule

bind diff_drive_odometry_update_core ddo_check u_ddo_check (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_operation  (req.operation),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_pose_x     (rsp.pose_x),
  .rsp_pose_y     (rsp.pose_y),
  .rsp_pose_theta (rsp.pose_theta)
);
